// ===== hdl/frs_pkg.sv =====
// shared types, codes and constants for the serial frame receiver
// no dependencies; imported by every module of the block
package frs_pkg;

   // field widths fixed by the interface
   localparam int LENGTH_BITS_DEF = 32;
   localparam int POS_W           = 32;
   localparam int DATA_W          = 8;
   localparam int FUNC_W          = 2;
   localparam int PHASE_W         = 3;
   localparam int CSR_IDX_W       = 2;

   // item function codes
   localparam logic [FUNC_W-1:0] FUNC_BYTE    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_TIMEOUT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;

   // receiver phase codes
   localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
   localparam logic [PHASE_W-1:0] PH_HEAD1 = 3'd1;
   localparam logic [PHASE_W-1:0] PH_HEAD2 = 3'd2;
   localparam logic [PHASE_W-1:0] PH_DATA  = 3'd3;
   localparam logic [PHASE_W-1:0] PH_DONE  = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_HDR  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_HDR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LEN    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEN    = 2'd3;

   // register reset values
   localparam logic [DATA_W-1:0] RST_FIRST_HDR  = 8'd126;
   localparam logic [DATA_W-1:0] RST_SECOND_HDR = 8'd85;
   localparam logic [DATA_W-1:0] RST_MIN_LEN    = 8'd1;
   localparam logic [DATA_W-1:0] RST_MAX_LEN    = 8'd255;

   // frame layout
   localparam int HDR_LEN         = 3;   // two header bytes plus length byte
   localparam int EXT_BASE        = 12;  // extended frame base added to min length
   localparam int EXT_FIELD_FIRST = 14;  // first byte of extended length field
   localparam int EXT_FIELD_LAST  = 17;  // last byte of extended length field

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [DATA_W-1:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic               store_valid;
      logic [POS_W-1:0]   store_position;
      logic [DATA_W-1:0]  store_data;
      logic               frame_done;
      logic [POS_W-1:0]   frame_length;
      logic [PHASE_W-1:0] phase_code;
   } rsp_type;

   typedef struct packed {
      logic [DATA_W-1:0] first_hdr;
      logic [DATA_W-1:0] second_hdr;
      logic [DATA_W-1:0] min_len;
      logic [DATA_W-1:0] max_len;
   } cfg_type;

endpackage

// ===== hdl/frs_csr.sv =====
// configuration register file of the serial frame receiver
// depends on frs_pkg
module frs_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [frs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [frs_pkg::DATA_W-1:0]    csr_wdata,
   output frs_pkg::cfg_type              cfg
);
   import frs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid && csr_ready;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_index)
            CSR_FIRST_HDR:  cfg_in.first_hdr  = csr_wdata;
            CSR_SECOND_HDR: cfg_in.second_hdr = csr_wdata;
            CSR_MIN_LEN:    cfg_in.min_len    = csr_wdata;
            CSR_MAX_LEN:    cfg_in.max_len    = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_hdr  <= RST_FIRST_HDR;
         cfg_ff.second_hdr <= RST_SECOND_HDR;
         cfg_ff.min_len    <= RST_MIN_LEN;
         cfg_ff.max_len    <= RST_MAX_LEN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/frs_core.sv =====
// frame state registers and the one-pass step logic of the serial frame receiver
// depends on frs_pkg
module frs_core #(
   parameter int LENGTH_BITS = frs_pkg::LENGTH_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  frs_pkg::req_type item,
   input  frs_pkg::cfg_type cfg,
   output frs_pkg::rsp_type result
);
   import frs_pkg::*;

   localparam int              SUM_W   = POS_W + 1;
   localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

   logic [PHASE_W-1:0]     phase_ff, phase_in;
   logic [LENGTH_BITS-1:0] byte_count_ff, byte_count_in;
   logic [LENGTH_BITS-1:0] expected_ff, expected_in;
   logic                   extended_ff, extended_in;

   logic                   st_valid;
   logic [LENGTH_BITS-1:0] st_pos;
   logic [DATA_W-1:0]      st_data;

   logic                   len_in_range;
   logic                   in_ext_field;
   logic [1:0]             shift_sel;
   logic [POS_W-1:0]       addend;
   logic [SUM_W-1:0]       ext_sum;
   logic [LENGTH_BITS-1:0] ext_expected;
   logic [LENGTH_BITS-1:0] data_expected;
   logic [LENGTH_BITS-1:0] count_inc;
   logic [DATA_W-1:0]      rx;

   assign rx           = item.rx_byte;
   assign len_in_range = (rx >= cfg.min_len) && (rx <= cfg.max_len);

   // extended length field, little-endian, one byte per position
   assign in_ext_field = extended_ff
                         && (byte_count_ff >= LENGTH_BITS'(EXT_FIELD_FIRST))
                         && (byte_count_ff <= LENGTH_BITS'(EXT_FIELD_LAST));
   assign shift_sel    = 2'(byte_count_ff[1:0] - 2'(EXT_FIELD_FIRST));
   assign addend       = POS_W'(rx) << {shift_sel, 3'b000};
   assign ext_sum      = SUM_W'(expected_ff) + SUM_W'(addend);
   assign ext_expected = (ext_sum > SUM_W'(LEN_MAX)) ? LEN_MAX : ext_sum[LENGTH_BITS-1:0];
   assign data_expected = in_ext_field ? ext_expected : expected_ff;
   assign count_inc    = byte_count_ff + LENGTH_BITS'(1);

   always_comb begin
      phase_in      = phase_ff;
      byte_count_in = byte_count_ff;
      expected_in   = expected_ff;
      extended_in   = extended_ff;
      st_valid      = 1'b0;
      st_pos        = '0;
      st_data       = '0;
      case (item.func)
         FUNC_BYTE: begin
            case (phase_ff)
               PH_IDLE: begin
                  if (rx == cfg.first_hdr) begin
                     phase_in      = PH_HEAD1;
                     byte_count_in = LENGTH_BITS'(1);
                     st_valid      = 1'b1;
                     st_data       = rx;
                  end
               end
               PH_HEAD1: begin
                  if (rx == cfg.second_hdr) begin
                     phase_in      = PH_HEAD2;
                     byte_count_in = LENGTH_BITS'(2);
                     st_valid      = 1'b1;
                     st_pos        = LENGTH_BITS'(1);
                     st_data       = rx;
                  end else if (rx == cfg.first_hdr) begin
                     // repeated first header byte restarts the match
                     byte_count_in = LENGTH_BITS'(1);
                     st_valid      = 1'b1;
                     st_data       = rx;
                  end else begin
                     phase_in      = PH_IDLE;
                     byte_count_in = '0;
                  end
               end
               PH_HEAD2: begin
                  if (len_in_range) begin
                     phase_in      = PH_DATA;
                     expected_in   = LENGTH_BITS'(rx) + LENGTH_BITS'(HDR_LEN);
                     extended_in   = 1'b0;
                     byte_count_in = LENGTH_BITS'(HDR_LEN);
                     st_valid      = 1'b1;
                     st_pos        = LENGTH_BITS'(2);
                     st_data       = rx;
                  end else if (rx == '0) begin
                     phase_in      = PH_DATA;
                     expected_in   = LENGTH_BITS'(cfg.min_len) + LENGTH_BITS'(EXT_BASE);
                     extended_in   = 1'b1;
                     byte_count_in = LENGTH_BITS'(HDR_LEN);
                     st_valid      = 1'b1;
                     st_pos        = LENGTH_BITS'(2);
                     st_data       = rx;
                  end else begin
                     phase_in      = PH_IDLE;
                     byte_count_in = '0;
                  end
               end
               PH_DATA: begin
                  expected_in   = data_expected;
                  st_valid      = 1'b1;
                  st_pos        = byte_count_ff;
                  st_data       = rx;
                  byte_count_in = count_inc;
                  if (count_inc >= data_expected) begin
                     phase_in = PH_DONE;
                  end
               end
               default: begin
                  // done (or unused code): bytes are dropped
                  phase_in = phase_ff;
               end
            endcase
         end
         FUNC_TIMEOUT: begin
            if (phase_ff == PH_HEAD1 || phase_ff == PH_HEAD2 || phase_ff == PH_DATA) begin
               if (byte_count_ff > LENGTH_BITS'(cfg.min_len)) begin
                  phase_in = PH_DONE;
               end else begin
                  phase_in      = PH_IDLE;
                  byte_count_in = '0;
               end
            end
         end
         FUNC_RELEASE: begin
            if (phase_ff == PH_DONE) begin
               phase_in      = PH_IDLE;
               byte_count_in = '0;
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   always_comb begin
      result.store_valid    = st_valid;
      result.store_position = POS_W'(st_pos);
      result.store_data     = st_data;
      result.frame_done     = (phase_in == PH_DONE);
      result.frame_length   = POS_W'(byte_count_in);
      result.phase_code     = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         byte_count_ff <= '0;
         expected_ff   <= '0;
         extended_ff   <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         byte_count_ff <= byte_count_in;
         expected_ff   <= expected_in;
         extended_ff   <= extended_in;
      end
   end

endmodule

// ===== hdl/serial_frame_receiver.sv =====
// top level of the serial frame receiver: input register, step core, result register
// depends on frs_pkg, frs_csr and frs_core
//
// usage
//   req channel: one transfer per item (func + rx_byte); func selects received
//     byte, idle timeout or release of a completed frame
//   rsp channel: exactly one transfer per accepted item, in order, with the
//     store position/data of an accepted byte and the frame status after it
//   csr channel: writes header bytes and the length window; always ready,
//     write only while no item is in flight
//   path: an item taken goes to the input register, then to the result register that drives rsp_valid
//   throughput: one item per cycle while rsp_stall is low; the step logic between
//     the input register and the result register is combinational
//   reset: synchronous; empties both registers, puts the receiver in idle with
//     a zero byte count and loads the register defaults
//   stall: a stalled result holds in the result register; one more item may
//     wait in the input register, then req_stall rises
module serial_frame_receiver #(
   parameter int LENGTH_BITS = frs_pkg::LENGTH_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // item input
   input  logic                          req_valid,
   output logic                          req_stall,
   input  frs_pkg::req_type              req_data,
   // result output
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output frs_pkg::rsp_type              rsp_data,
   // configuration writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [frs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [frs_pkg::DATA_W-1:0]    csr_wdata
);
   import frs_pkg::*;

   cfg_type cfg;

   // input register
   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type step_result;

   logic    out_load;   // result register free or being drained this cycle
   logic    step;       // item moves from input register to result register
   logic    req_xfer;

   frs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   frs_core #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (step_result)
   );

   // handshake
   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_load;
   assign req_stall = in_valid_ff && !out_load;
   assign req_xfer  = req_valid && !req_stall;

   // input register refills in the same cycle it empties
   always_comb begin
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   assign rsp_valid_in = out_load ? step : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_item_ff <= req_data;
      end
      if (step) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a waiting item is never dropped while the result side is blocked
   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step |=> in_valid_ff)
      else $error("waiting item lost from input register");

   // an accepted byte always advances the count to one past its position
   a_store_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.store_valid |->
         rsp_data.frame_length == rsp_data.store_position + POS_W'(1))
      else $error("frame length does not follow stored position");

   // idle means an empty frame with nothing stored
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.phase_code == PH_IDLE |->
         rsp_data.frame_length == '0 && !rsp_data.store_valid)
      else $error("idle result carries frame data");

endmodule
